// ===== src/esd_pkg.sv =====
// esd_pkg: constants, sequencer state type and month length table for the
// epoch seconds to calendar date converter; no dependencies
`default_nettype none

package esd_pkg;

    localparam int unsigned SecsPerDay   = 86400;
    localparam int unsigned SecsPerHour  = 3600;
    localparam int unsigned SecsPerMin   = 60;
    localparam int unsigned BaseYear     = 1970;
    localparam int unsigned DaysPerYear  = 365;
    localparam int unsigned DaysLeapYear = 366;
    // first day number past 2099-12-31
    localparam int unsigned FirstBadDay  = 47482;
    localparam int unsigned LastMonth    = 11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAYS,
        S_HOUR,
        S_MIN,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== src/epoch_seconds_to_date_unit.sv =====
// epoch_seconds_to_date_unit: seconds since 1970-01-01 00:00:00 to calendar
// date and time of day with one shared subtract and compare unit; uses esd_pkg
//
// usage
// - input channel i_in_valid / o_in_ready carries i_epoch_seconds; one
//   transaction in gives exactly one transaction out on o_out_valid /
//   i_out_ready with year, month, day, hour, minute, second, out_of_range
// - a single 32 bit subtractor/comparator does all the work under a
//   sequencer: 16 restoring steps for the day count, 5 for the hour, 6 for
//   the minute, one per whole year consumed (up to 129) and one per month
//   (up to 11), each walk ending in one failing compare (the month walk may
//   also end at December), and a final load step into the output register
// - inputs past 2099-12-31 23:59:59 skip the calendar walk and go straight
//   to the load step
// - o_in_ready is high only while the sequencer is idle, so one item is in
//   work at a time; the result sits in an output register, so a new item
//   is taken while an earlier result waits for i_out_ready
// - if the receiver stalls with a result still held, a finished item waits
//   in the sequencer until the register frees
// - synchronous active low reset empties the sequencer and the output
//   register; no clearing pass, ready once reset has set the sequencer idle
`default_nettype none

module epoch_seconds_to_date_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second,
    output logic             o_out_of_range
);

    esd_pkg::t_state r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_days, n_days;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [7:0]  r_yoff, n_yoff;
    logic [3:0]  r_mon, n_mon;
    logic        r_oor, n_oor;

    logic        r_out_valid, n_out_valid;
    logic        w_load;
    logic [11:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_day;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_min;
    logic [5:0]  r_o_sec;
    logic        r_o_oor;

    // shared subtract and compare unit
    logic [31:0] w_op;
    logic [32:0] w_diff;
    logic        w_ge;
    logic        w_leap;
    logic [15:0] w_quo_sh;

    assign w_leap   = (r_yoff[1:0] == 2'd2);
    assign w_diff   = {1'b0, r_acc} - {1'b0, w_op};
    assign w_ge     = ~w_diff[32];
    assign w_quo_sh = {r_quo[14:0], w_ge};

    always_comb begin
        case (r_state)
            esd_pkg::S_DAYS:  w_op = 32'(esd_pkg::SecsPerDay) << r_cnt;
            esd_pkg::S_HOUR:  w_op = 32'(esd_pkg::SecsPerHour) << r_cnt;
            esd_pkg::S_MIN:   w_op = 32'(esd_pkg::SecsPerMin) << r_cnt;
            esd_pkg::S_YEAR:  w_op = w_leap ? 32'(esd_pkg::DaysLeapYear)
                                            : 32'(esd_pkg::DaysPerYear);
            esd_pkg::S_MONTH: w_op = {27'd0, esd_pkg::month_len(r_mon, w_leap)};
            default:          w_op = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_quo  <= n_quo;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_yoff <= n_yoff;
        r_mon  <= n_mon;
        r_oor  <= n_oor;
        if (w_load) begin
            r_o_year  <= r_oor ? 12'd0 : 12'(esd_pkg::BaseYear) + {4'd0, r_yoff};
            r_o_month <= r_oor ? 4'd0 : r_mon + 4'd1;
            r_o_day   <= r_oor ? 5'd0 : r_acc[4:0] + 5'd1;
            r_o_hour  <= r_hour;
            r_o_min   <= r_min;
            r_o_sec   <= r_sec;
            r_o_oor   <= r_oor;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_days      = r_days;
        n_hour      = r_hour;
        n_min       = r_min;
        n_sec       = r_sec;
        n_yoff      = r_yoff;
        n_mon       = r_mon;
        n_oor       = r_oor;
        w_load      = 1'b0;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_in_ready  = (r_state == esd_pkg::S_IDLE);

        case (r_state)
            esd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_acc   = i_epoch_seconds;
                    n_quo   = 16'd0;
                    n_cnt   = 4'd15;
                    n_state = esd_pkg::S_DAYS;
                end
            end
            esd_pkg::S_DAYS: begin
                if (w_ge) begin
                    n_acc = w_diff[31:0];
                end
                n_quo = w_quo_sh;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_days  = w_quo_sh;
                    n_quo   = 16'd0;
                    n_cnt   = 4'd4;
                    n_state = esd_pkg::S_HOUR;
                end
            end
            esd_pkg::S_HOUR: begin
                if (w_ge) begin
                    n_acc = w_diff[31:0];
                end
                n_quo = w_quo_sh;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_hour  = w_quo_sh[4:0];
                    n_quo   = 16'd0;
                    n_cnt   = 4'd5;
                    n_state = esd_pkg::S_MIN;
                end
            end
            esd_pkg::S_MIN: begin
                if (w_ge) begin
                    n_acc = w_diff[31:0];
                end
                n_quo = w_quo_sh;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_min   = w_quo_sh[5:0];
                    n_sec   = w_ge ? w_diff[5:0] : r_acc[5:0];
                    n_acc   = {16'd0, r_days};
                    n_yoff  = 8'd0;
                    n_mon   = 4'd0;
                    n_oor   = (r_days >= 16'(esd_pkg::FirstBadDay));
                    n_state = n_oor ? esd_pkg::S_DONE : esd_pkg::S_YEAR;
                end
            end
            esd_pkg::S_YEAR: begin
                if (w_ge) begin
                    n_acc  = w_diff[31:0];
                    n_yoff = r_yoff + 8'd1;
                end else begin
                    n_state = esd_pkg::S_MONTH;
                end
            end
            esd_pkg::S_MONTH: begin
                if (w_ge && (r_mon < 4'(esd_pkg::LastMonth))) begin
                    n_acc = w_diff[31:0];
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_state = esd_pkg::S_DONE;
                end
            end
            esd_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = esd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = esd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day          = r_o_day;
    assign o_hour         = r_o_hour;
    assign o_minute       = r_o_min;
    assign o_second       = r_o_sec;
    assign o_out_of_range = r_o_oor;

`ifndef SYNTHESIS
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == esd_pkg::S_DAYS))
        else $error("accepted transaction did not start the day division");

    a_tod_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == esd_pkg::S_HOUR) |-> (r_acc < 32'(esd_pkg::SecsPerDay)))
        else $error("day division remainder not below one day");

    a_year_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_of_range) |->
            (o_year >= 12'd1970 && o_year <= 12'd2099))
        else $error("year out of range in result");

    a_date_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_of_range) |->
            (o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1 && o_hour <= 5'd23
             && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("date or time field out of range in result");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |->
            (o_year == 12'd0 && o_month == 4'd0 && o_day == 5'd0))
        else $error("date fields not cleared for out of range input");
`endif

endmodule

`default_nettype wire

// ===== tb/epoch_seconds_to_date_unit_test.sv =====
// epoch_seconds_to_date_unit_test: self-checking bench for the seconds to calendar
// date converter; corner values, month edges and random seconds, with idling on
// both channels; needs only epoch_seconds_to_date_unit and esd_pkg
module epoch_seconds_to_date_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SecsDay    = 86400;
    localparam int unsigned SecsHour   = 3600;
    localparam int unsigned SecsMin    = 60;
    localparam int unsigned EpochYear  = 1970;
    localparam int unsigned FinalYear  = 2099;
    localparam int unsigned LastSecond = 32'd4102444799;
    localparam int unsigned FebIndex   = 1;
    localparam int unsigned DecIndex   = 11;
    localparam int          IdlePct    = 35;
    localparam int          CycleLimit = 2_000_000;
    localparam int          SettleCycles = 200;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        out_of_range;
    } t_calendar;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_epoch_seconds = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic        o_out_of_range;

    t_calendar pending_dates[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        steady = 1'b0;

    epoch_seconds_to_date_unit dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned year_length(input int unsigned yr);
        return (yr % 4 == 0) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
        int unsigned len;
        case (mon)
            FebIndex:     len = (yr % 4 == 0) ? 29 : 28;
            3, 5, 8, 10:  len = 30;
            default:      len = 31;
        endcase
        return len;
    endfunction

    function automatic t_calendar calendar_of(input logic [31:0] secs);
        t_calendar   r;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        r = '0;
        days = secs / SecsDay;
        tod = secs % SecsDay;
        r.hour = 5'(tod / SecsHour);
        r.minute = 6'((tod % SecsHour) / SecsMin);
        r.second = 6'(tod % SecsMin);
        if (secs > LastSecond) begin
            r.out_of_range = 1'b1;
        end else begin
            yr = EpochYear;
            mon = 0;
            while (days >= year_length(yr)) begin
                days -= year_length(yr);
                yr++;
            end
            while (mon < DecIndex && days >= month_length(mon, yr)) begin
                days -= month_length(mon, yr);
                mon++;
            end
            r.year = 12'(yr);
            r.month = 4'(mon + 1);
            r.day = 5'(days + 1);
        end
        return r;
    endfunction

    // day number since the epoch of a calendar date, month zero based
    function automatic int unsigned day_number(input int unsigned yr, input int unsigned mon,
                                               input int unsigned dom);
        int unsigned n;
        n = dom - 1;
        for (int unsigned y = EpochYear; y < yr; y++) n += year_length(y);
        for (int unsigned m = 0; m < mon; m++) n += month_length(m, yr);
        return n;
    endfunction

    task automatic send_seconds(input logic [31:0] secs);
        while (!steady && $urandom_range(99) < IdlePct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_epoch_seconds <= secs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_dates.push_back(calendar_of(secs));
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_month_edge;
        int unsigned yr;
        int unsigned mon;
        int unsigned dom;
        int unsigned tod;
        yr = $urandom_range(FinalYear, EpochYear);
        mon = $urandom_range(DecIndex);
        dom = $urandom_range(1) ? month_length(mon, yr) : 1;
        case ($urandom_range(2))
            0:       tod = 0;
            1:       tod = SecsDay - 1;
            default: tod = $urandom_range(SecsDay - 1);
        endcase
        send_seconds(day_number(yr, mon, dom) * SecsDay + tod);
    endtask

    task automatic test_corners;
        logic [31:0] corners [0:23];
        corners = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                    32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600,
                    32'd94607999, 32'd94608000, 32'd94694399, 32'd94694400,
                    32'd951782400, 32'd2147483647, 32'd2147483648, 32'd4102358400,
                    32'd4102444799, 32'd4102444800, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                    32'h5555_5555};
        foreach (corners[i]) send_seconds(corners[i]);
    endtask

    task automatic test_month_edges(input int count);
        repeat (count) send_month_edge();
    endtask

    task automatic test_steady_stream(input int count);
        steady = 1'b1;
        repeat (count) send_month_edge();
        repeat (count / 2) send_seconds($urandom_range(LastSecond));
        steady = 1'b0;
    endtask

    task automatic test_random_calendar(input int count);
        repeat (count) send_seconds($urandom_range(LastSecond));
    endtask

    task automatic test_random_word(input int count);
        repeat (count) send_seconds($urandom());
    endtask

    task automatic test_range_limit(input int count);
        repeat (count) send_seconds(LastSecond - 200 + $urandom_range(400));
    endtask

    task automatic test_drain_pause(input int count);
        repeat (count) send_seconds($urandom_range(LastSecond));
        wait_drained();
        repeat (count) send_month_edge();
    endtask

    // result channel: ready pattern and field-wise comparison
    always @(posedge i_clk) begin
        t_calendar want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_dates.size() == 0) begin
                $error("result transaction with no expectation waiting");
                error_count++;
            end else begin
                want = pending_dates.pop_front();
                if (o_year !== want.year) begin
                    $error("year: expected %0d, actual %0d", want.year, o_year);
                    error_count++;
                end
                if (o_month !== want.month) begin
                    $error("month: expected %0d, actual %0d", want.month, o_month);
                    error_count++;
                end
                if (o_day !== want.day) begin
                    $error("day: expected %0d, actual %0d", want.day, o_day);
                    error_count++;
                end
                if (o_hour !== want.hour) begin
                    $error("hour: expected %0d, actual %0d", want.hour, o_hour);
                    error_count++;
                end
                if (o_minute !== want.minute) begin
                    $error("minute: expected %0d, actual %0d", want.minute, o_minute);
                    error_count++;
                end
                if (o_second !== want.second) begin
                    $error("second: expected %0d, actual %0d", want.second, o_second);
                    error_count++;
                end
                if (o_out_of_range !== want.out_of_range) begin
                    $error("out_of_range: expected %0d, actual %0d",
                           want.out_of_range, o_out_of_range);
                    error_count++;
                end
            end
        end
        i_out_ready <= steady || ($urandom_range(99) >= IdlePct);
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("epoch_seconds_to_date_unit_test failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_month_edges(300);
        test_drain_pause(25);
        test_random_calendar(850);
        test_steady_stream(200);
        test_random_word(400);
        test_range_limit(50);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        if (error_count == 0 && pending_dates.size() == 0) begin
            $display("epoch_seconds_to_date_unit_test passed");
        end else begin
            $display("epoch_seconds_to_date_unit_test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/esd_pkg.sv
src/epoch_seconds_to_date_unit.sv
tb/epoch_seconds_to_date_unit_test.sv
